@@ src/peer_wire_message_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Peer wire message parser assertion macros
// Shared immediate-implication and next-cycle checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PEER_WIRE_MESSAGE_PARSER_MACROS_SVH
`define PEER_WIRE_MESSAGE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peer wire parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define PWMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peer wire parser check failed");

`endif

@@ src/pwmp_pkg.sv @@
// ----------------------------------------------------------------------------
// Peer wire message parser package
// Event and message type codes, handshake constants and small lookup
// functions for the receive-side parser.
// ----------------------------------------------------------------------------
package pwmp_pkg;

    // Event codes on the result channel.
    localparam logic [1:0] EV_HS_OK   = 2'd0;
    localparam logic [1:0] EV_HS_FAIL = 2'd1;
    localparam logic [1:0] EV_HEADER  = 2'd2;
    localparam logic [1:0] EV_PAYLOAD = 2'd3;

    // Message type codes.
    localparam logic [3:0] MT_KEEPALIVE     = 4'd0;
    localparam logic [3:0] MT_CHOKE         = 4'd1;
    localparam logic [3:0] MT_UNCHOKE       = 4'd2;
    localparam logic [3:0] MT_INTERESTED    = 4'd3;
    localparam logic [3:0] MT_NOTINTERESTED = 4'd4;
    localparam logic [3:0] MT_HAVE          = 4'd5;
    localparam logic [3:0] MT_BITFIELD      = 4'd6;
    localparam logic [3:0] MT_PIECE         = 4'd7;
    localparam logic [3:0] MT_OTHER         = 4'd8;

    // Raw message ids with a special mapping.
    localparam logic [7:0] ID_LAST_PLAIN = 8'd5;
    localparam logic [7:0] ID_PIECE      = 8'd7;

    // Handshake layout.
    localparam logic [7:0]  HS_PSTRLEN    = 8'd19;
    localparam logic [31:0] HS_PROTO_LAST = 32'd19;
    localparam logic [31:0] HS_HASH_FIRST = 32'd28;
    localparam logic [31:0] HS_HASH_END   = 32'd48;
    localparam logic [31:0] HS_LAST_BYTE  = 32'd67;

    // Message framing.
    localparam logic [31:0] LEN_LAST_BYTE  = 32'd3;
    localparam logic [31:0] HAVE_LAST_BYTE = 32'd4;
    localparam logic [31:0] INDEX_LAST     = 32'd4;
    localparam logic [31:0] PIECE_HDR_LAST = 32'd8;
    localparam logic [31:0] PIECE_HDR_LEN  = 32'd9;

    // Configuration register indexes.
    localparam logic [1:0] REG_HASH_0 = 2'd0;
    localparam logic [1:0] REG_HASH_1 = 2'd1;
    localparam logic [1:0] REG_HASH_2 = 2'd2;

    // Character of the protocol string at position pos (1 to 19).
    function automatic logic [7:0] proto_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd1:    c = 8'h42; // B
            5'd2:    c = 8'h69; // i
            5'd3:    c = 8'h74; // t
            5'd4:    c = 8'h54; // T
            5'd5:    c = 8'h6f; // o
            5'd6:    c = 8'h72; // r
            5'd7:    c = 8'h72; // r
            5'd8:    c = 8'h65; // e
            5'd9:    c = 8'h6e; // n
            5'd10:   c = 8'h74; // t
            5'd11:   c = 8'h20; // space
            5'd12:   c = 8'h70; // p
            5'd13:   c = 8'h72; // r
            5'd14:   c = 8'h6f; // o
            5'd15:   c = 8'h74; // t
            5'd16:   c = 8'h6f; // o
            5'd17:   c = 8'h63; // c
            5'd18:   c = 8'h6f; // o
            5'd19:   c = 8'h6c; // l
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Map a raw message id to its message type.
    function automatic logic [3:0] id_to_type(input logic [7:0] id);
        logic [3:0] t;
        if (id <= ID_LAST_PLAIN)
        begin
            t = id[3:0] + 4'd1;
        end
        else if (id == ID_PIECE)
        begin
            t = MT_PIECE;
        end
        else
        begin
            t = MT_OTHER;
        end
        return t;
    endfunction

endpackage

@@ src/peer_wire_message_parser.sv @@
// Each accepted byte passes from the input register into the parser; any result goes to the result register.
// Throughput: one byte per cycle; the input register and the result register each advance
// whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): parser returns to the handshake phase, info hash clears,
// input and result registers empty.
// ----------------------------------------------------------------------------
// Peer wire message parser
// Checks the 68-byte peer handshake against the configured info hash, then
// deframes length-prefixed messages and reports headers and payload bytes.
// ----------------------------------------------------------------------------
`include "peer_wire_message_parser_macros.svh"

module peer_wire_message_parser
    import pwmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [3:0]  msg_type,
    output logic [7:0]  msg_id,
    output logic [31:0] msg_length,
    output logic [31:0] piece_index,
    output logic [31:0] block_begin,
    output logic [7:0]  data_byte,
    output logic [31:0] data_offset,
    output logic        end_of_message,
    output logic        malformed
);

    typedef enum logic [2:0] {
        PH_HANDSHAKE,
        PH_DEAD,
        PH_LENGTH,
        PH_ID,
        PH_BODY
    } phase_t;

    // Configuration registers.
    logic [63:0] hash0_reg;
    logic [63:0] hash1_reg;
    logic [31:0] hash2_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic        good_reg, good_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] beg_reg, beg_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  id_reg, id_next;

    // Result register.
    logic        out_valid_reg;
    logic [1:0]  event_reg;
    logic [3:0]  mtype_reg;
    logic [7:0]  mid_reg;
    logic [31:0] mlen_reg;
    logic [31:0] pidx_reg;
    logic [31:0] bbeg_reg;
    logic [7:0]  dbyte_reg;
    logic [31:0] doff_reg;
    logic        eom_reg;
    logic        mal_reg;

    // Result of the current step.
    logic        res_fire;
    logic [1:0]  res_event;
    logic        res_zero;
    logic [7:0]  res_data;
    logic [31:0] res_off;
    logic        res_eom;
    logic        res_mal;

    logic        advance;
    logic        process;
    logic        cfg_write;
    logic [159:0] hash_all;
    logic [7:0]  hash_bytes [20];
    logic [5:0]  hash_pos;
    logic        body_eom;
    logic        id_eom;
    logic [3:0]  id_type;

    // Configuration access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash0_reg <= '0;
            hash1_reg <= '0;
            hash2_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_HASH_0: hash0_reg <= pwdata;
                REG_HASH_1: hash1_reg <= pwdata;
                REG_HASH_2: hash2_reg <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_HASH_0: prdata = hash0_reg;
            REG_HASH_1: prdata = hash1_reg;
            REG_HASH_2: prdata = {32'd0, hash2_reg};
            default:    prdata = '0;
        endcase
    end

    // Info hash split into bytes, byte 0 first.
    assign hash_all = {hash0_reg, hash1_reg, hash2_reg};

    always_comb
    begin
        for (int k = 0; k < 20; k++)
        begin
            hash_bytes[k] = hash_all[159 - 8 * k -: 8];
        end
    end

    assign hash_pos = count_reg[5:0] - HS_HASH_FIRST[5:0];

    // Handshake between the input register and the result register.
    assign advance  = !out_valid_reg || !out_stall;
    assign process  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign body_eom = (count_reg + 32'd1) == len_reg;
    assign id_eom   = len_reg == 32'd1;
    assign id_type  = id_to_type(in_byte_reg);

    // One parsing step for the byte in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        good_next  = good_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        beg_next   = beg_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        res_fire   = 1'b0;
        res_event  = EV_HEADER;
        res_zero   = 1'b0;
        res_data   = '0;
        res_off    = '0;
        res_eom    = 1'b0;
        res_mal    = 1'b0;

        case (phase_reg)
            PH_HANDSHAKE:
            begin
                if (count_reg == 32'd0)
                begin
                    if (in_byte_reg != HS_PSTRLEN)
                    begin
                        good_next = 1'b0;
                    end
                end
                else if (count_reg <= HS_PROTO_LAST)
                begin
                    if (in_byte_reg != proto_char(count_reg[4:0]))
                    begin
                        good_next = 1'b0;
                    end
                end
                else if (count_reg >= HS_HASH_FIRST && count_reg < HS_HASH_END)
                begin
                    if (in_byte_reg != hash_bytes[hash_pos[4:0]])
                    begin
                        good_next = 1'b0;
                    end
                end

                if (count_reg >= HS_LAST_BYTE)
                begin
                    res_fire   = 1'b1;
                    res_zero   = 1'b1;
                    res_event  = good_next ? EV_HS_OK : EV_HS_FAIL;
                    phase_next = good_next ? PH_LENGTH : PH_DEAD;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + 32'd1;
                end
            end

            PH_LENGTH:
            begin
                // Big-endian length prefix, restarted on its first byte.
                if (count_reg == 32'd0)
                begin
                    len_next = {24'd0, in_byte_reg};
                end
                else
                begin
                    len_next = {len_reg[23:0], in_byte_reg};
                end
                count_next = count_reg + 32'd1;
                if (count_reg >= LEN_LAST_BYTE)
                begin
                    count_next = '0;
                    idx_next   = '0;
                    beg_next   = '0;
                    if (len_next == 32'd0)
                    begin
                        type_next = MT_KEEPALIVE;
                        id_next   = '0;
                        res_fire  = 1'b1;
                        res_eom   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ID;
                    end
                end
            end

            PH_ID:
            begin
                id_next   = in_byte_reg;
                type_next = id_type;
                // Have and piece report their header once their fields arrive or the message ends.
                if ((id_type != MT_HAVE && id_type != MT_PIECE) || id_eom)
                begin
                    res_fire = 1'b1;
                    res_eom  = id_eom;
                    res_mal  = (id_type == MT_PIECE) && (len_reg < PIECE_HDR_LEN);
                end
                count_next = id_eom ? 32'd0 : 32'd1;
                phase_next = id_eom ? PH_LENGTH : PH_BODY;
            end

            PH_BODY:
            begin
                if (type_reg == MT_HAVE)
                begin
                    if (count_reg <= INDEX_LAST)
                    begin
                        idx_next = {idx_reg[23:0], in_byte_reg};
                        if (count_reg == HAVE_LAST_BYTE || body_eom)
                        begin
                            res_fire = 1'b1;
                            res_eom  = body_eom;
                        end
                    end
                end
                else if (type_reg == MT_PIECE)
                begin
                    if (count_reg <= PIECE_HDR_LAST)
                    begin
                        if (count_reg <= INDEX_LAST)
                        begin
                            idx_next = {idx_reg[23:0], in_byte_reg};
                        end
                        else
                        begin
                            beg_next = {beg_reg[23:0], in_byte_reg};
                        end
                        if (count_reg == PIECE_HDR_LAST || body_eom)
                        begin
                            res_fire = 1'b1;
                            res_eom  = body_eom;
                            res_mal  = len_reg < PIECE_HDR_LEN;
                        end
                    end
                    else
                    begin
                        res_fire  = 1'b1;
                        res_event = EV_PAYLOAD;
                        res_data  = in_byte_reg;
                        res_off   = count_reg - PIECE_HDR_LEN;
                        res_eom   = body_eom;
                    end
                end
                else if (type_reg == MT_BITFIELD)
                begin
                    res_fire  = 1'b1;
                    res_event = EV_PAYLOAD;
                    res_data  = in_byte_reg;
                    res_off   = count_reg - 32'd1;
                    res_eom   = body_eom;
                end

                if (body_eom)
                begin
                    phase_next = PH_LENGTH;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + 32'd1;
                end
            end

            PH_DEAD:
            begin
                // A failed handshake swallows every later byte.
            end

            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HANDSHAKE;
            count_reg <= '0;
            good_reg  <= 1'b1;
            len_reg   <= '0;
            idx_reg   <= '0;
            beg_reg   <= '0;
            type_reg  <= MT_KEEPALIVE;
            id_reg    <= '0;
        end
        else if (process)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            good_reg  <= good_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            beg_reg   <= beg_next;
            type_reg  <= type_next;
            id_reg    <= id_next;
        end
    end

    // Result register: valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= process && res_fire;
        end
    end

    // Result register: payload, with handshake results cleared to zero.
    always_ff @(posedge clk)
    begin
        if (process && res_fire)
        begin
            event_reg <= res_event;
            mtype_reg <= res_zero ? MT_KEEPALIVE : type_next;
            mid_reg   <= res_zero ? 8'd0 : id_next;
            mlen_reg  <= res_zero ? 32'd0 : len_next;
            pidx_reg  <= res_zero ? 32'd0 : idx_next;
            bbeg_reg  <= res_zero ? 32'd0 : beg_next;
            dbyte_reg <= res_data;
            doff_reg  <= res_off;
            eom_reg   <= res_eom;
            mal_reg   <= res_mal;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign msg_type       = mtype_reg;
    assign msg_id         = mid_reg;
    assign msg_length     = mlen_reg;
    assign piece_index    = pidx_reg;
    assign block_begin    = bbeg_reg;
    assign data_byte      = dbyte_reg;
    assign data_offset    = doff_reg;
    assign end_of_message = eom_reg;
    assign malformed      = mal_reg;

    // Checks on the parser's own logic.
    `PWMP_ASSERT_NEXT(a_dead_sticks, phase_reg == PH_DEAD, phase_reg == PH_DEAD)
    `PWMP_ASSERT_NEXT(a_in_held, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))
    `PWMP_ASSERT_NOW(a_hs_clean,
        out_valid_reg && (event_reg == EV_HS_OK || event_reg == EV_HS_FAIL),
        mtype_reg == MT_KEEPALIVE && !eom_reg && !mal_reg)
    `PWMP_ASSERT_NOW(a_mal_piece, out_valid_reg && mal_reg,
        event_reg == EV_HEADER && mtype_reg == MT_PIECE)
    `PWMP_ASSERT_NOW(a_payload_type, out_valid_reg && event_reg == EV_PAYLOAD,
        mtype_reg == MT_BITFIELD || mtype_reg == MT_PIECE)

endmodule
